// ===== hw/rtl/dq_pkg.sv =====
package dq_pkg;

	// default ring depth in words
	localparam int unsigned DEPTH_DEF = 1024;

	// payload widths fixed by the interface
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ACT_W   = 3;
	localparam int unsigned COUNT_W = 11;

	// action codes; the unused codes behave as a peek
	localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
	localparam logic [ACT_W-1:0] ACT_PEEK       = 3'd4;

	typedef struct packed {
		logic [ACT_W-1:0]         action;
		logic signed [WORD_W-1:0] push_value;
	} dq_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] popped_value;
		logic                     popped_valid;
		logic                     overflow;
		logic [COUNT_W-1:0]       entry_count;
		logic                     is_empty;
		logic signed [WORD_W-1:0] front_value;
		logic signed [WORD_W-1:0] back_value;
		logic                     ends_valid;
	} dq_rsp_t;

endpackage

// ===== hw/rtl/dq_chan_if.sv =====
// request channel into the deque
interface dq_req_if import dq_pkg::*; ();
	logic    valid;
	logic    ready;
	dq_req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// result channel out of the deque
interface dq_rsp_if import dq_pkg::*; ();
	logic    valid;
	logic    ready;
	dq_rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit words in a DEPTH-entry ring memory with one
// write and one registered read port. Each request pushes at either end, pops from
// either end or peeks, and returns exactly one result with the popped word, an
// overflow flag for a push into a full ring, the count and the front and back
// words. Both end words are kept in registers, so pushes, peeks and a pop that
// empties the deque register their result as the request is taken; a pop that
// leaves one or more words goes through ST_READ, because the new end word comes
// from the registered memory read port. A result waits in an output register and
// a new request is taken in the cycle that result is taken. The memory needs no
// clearing after reset: only entries written by a push are ever read.
module double_ended_queue import dq_pkg::*; #(
	parameter int unsigned DEPTH = DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	dq_req_if.sink     req,
	dq_rsp_if.source   rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	typedef enum logic {ST_IDLE, ST_READ} state_t;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
		return (idx == LAST_IDX) ? '0 : idx + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
		return (idx == '0) ? LAST_IDX : idx - AW'(1);
	endfunction

	function automatic dq_rsp_t make_rsp(
		input logic [WORD_W-1:0] popped,
		input logic              popped_ok,
		input logic              ovf,
		input logic [CW-1:0]     cnt,
		input logic [WORD_W-1:0] frontw,
		input logic [WORD_W-1:0] backw
	);
		dq_rsp_t r;
		logic    held;
		held           = (cnt != '0);
		r.popped_value = popped;
		r.popped_valid = popped_ok;
		r.overflow     = ovf;
		r.entry_count  = COUNT_W'(cnt);
		r.is_empty     = !held;
		r.front_value  = held ? frontw : '0;
		r.back_value   = held ? backw : '0;
		r.ends_valid   = held;
		return r;
	endfunction

	// ring memory
	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] mem_rdata_q;

	state_t            state_q;
	logic [AW-1:0]     head_q;
	logic [AW-1:0]     tail_q;
	logic [CW-1:0]     count_q;
	logic [WORD_W-1:0] front_q;
	logic [WORD_W-1:0] back_q;
	logic [WORD_W-1:0] popped_q;
	logic              read_front_q;
	logic              rsp_valid_q;
	dq_rsp_t           rsp_q;

	logic              acc;
	logic              full;
	logic              empty;
	logic [AW-1:0]     head_m1;
	logic [AW-1:0]     head_p1;
	logic [AW-1:0]     tail_m1;
	logic [AW-1:0]     tail_m2;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic              go_read;
	logic [AW-1:0]     nxt_head;
	logic [AW-1:0]     nxt_tail;
	logic [CW-1:0]     nxt_count;
	logic [WORD_W-1:0] nxt_front;
	logic [WORD_W-1:0] nxt_back;
	logic [WORD_W-1:0] nxt_popped;
	logic              nxt_popped_ok;
	logic              nxt_ovf;
	logic              is_push;

	assign req.ready = (state_q == ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign acc       = req.valid && req.ready;
	assign full      = (count_q == FULL_CNT);
	assign empty     = (count_q == '0);
	assign head_m1   = ring_dec(head_q);
	assign head_p1   = ring_inc(head_q);
	assign tail_m1   = ring_dec(tail_q);
	assign tail_m2   = ring_dec(tail_m1);
	assign is_push   = (req.data.action == ACT_PUSH_FRONT) ||
	                   (req.data.action == ACT_PUSH_BACK);

	// decode one request against the cached ends
	always_comb begin
		mem_we        = 1'b0;
		mem_waddr     = head_m1;
		mem_re        = 1'b0;
		mem_raddr     = head_p1;
		go_read       = 1'b0;
		nxt_head      = head_q;
		nxt_tail      = tail_q;
		nxt_count     = count_q;
		nxt_front     = front_q;
		nxt_back      = back_q;
		nxt_popped    = '0;
		nxt_popped_ok = 1'b0;
		nxt_ovf       = 1'b0;
		case (req.data.action)
			ACT_PUSH_FRONT: begin
				if (full) begin
					nxt_ovf = 1'b1;
				end else begin
					mem_we    = acc;
					mem_waddr = head_m1;
					nxt_head  = head_m1;
					nxt_count = count_q + CW'(1);
					nxt_front = req.data.push_value;
					if (empty) begin
						nxt_back = req.data.push_value;
					end
				end
			end
			ACT_PUSH_BACK: begin
				if (full) begin
					nxt_ovf = 1'b1;
				end else begin
					mem_we    = acc;
					mem_waddr = tail_q;
					nxt_tail  = ring_inc(tail_q);
					nxt_count = count_q + CW'(1);
					nxt_back  = req.data.push_value;
					if (empty) begin
						nxt_front = req.data.push_value;
					end
				end
			end
			ACT_POP_FRONT: begin
				if (!empty) begin
					nxt_popped    = front_q;
					nxt_popped_ok = 1'b1;
					nxt_head      = head_p1;
					nxt_count     = count_q - CW'(1);
					go_read       = (count_q > CW'(1));
					mem_re        = acc && go_read;
					mem_raddr     = head_p1;
				end
			end
			ACT_POP_BACK: begin
				if (!empty) begin
					nxt_popped    = back_q;
					nxt_popped_ok = 1'b1;
					nxt_tail      = tail_m1;
					nxt_count     = count_q - CW'(1);
					go_read       = (count_q > CW'(1));
					mem_re        = acc && go_read;
					mem_raddr     = tail_m2;
				end
			end
			default: begin
			end
		endcase
	end

	// memory ports
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= req.data.push_value;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	// sequencer, pointers, cached ends and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			front_q      <= '0;
			back_q       <= '0;
			popped_q     <= '0;
			read_front_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
			rsp_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						head_q   <= nxt_head;
						tail_q   <= nxt_tail;
						count_q  <= nxt_count;
						front_q  <= nxt_front;
						back_q   <= nxt_back;
						popped_q <= nxt_popped;
						read_front_q <= (req.data.action == ACT_POP_FRONT);
						if (go_read) begin
							state_q     <= ST_READ;
							rsp_valid_q <= 1'b0;
						end else begin
							rsp_valid_q <= 1'b1;
							rsp_q <= make_rsp(nxt_popped, nxt_popped_ok, nxt_ovf,
							                  nxt_count, nxt_front, nxt_back);
						end
					end else if (rsp.ready) begin
						// waiting result taken, nothing new
						rsp_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					// new end word arrives from the memory
					if (read_front_q) begin
						front_q <= mem_rdata_q;
						rsp_q   <= make_rsp(popped_q, 1'b1, 1'b0, count_q,
						                    mem_rdata_q, back_q);
					end else begin
						back_q <= mem_rdata_q;
						rsp_q  <= make_rsp(popped_q, 1'b1, 1'b0, count_q,
						                   front_q, mem_rdata_q);
					end
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	// count stays within the ring
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("deque count above depth");

	// the output register is free while a memory read is pending
	a_read_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> !rsp_valid_q)
		else $error("result pending during end-word read");

	// a push that fits grows the count by one
	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_push && !full |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow count");

	// a request that needs no memory read leaves a result behind
	a_fast_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !go_read |=> rsp_valid_q && state_q == ST_IDLE)
		else $error("missing result after request");

endmodule
